// ----- src/ti_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ti_pkg
// Widths and pipeline depths shared by the triangle incenter modules.
// ----------------------------------------------------------------------------
package ti_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int D2_W    = 33;
  localparam int FRAC_W  = 8;
  localparam int RAD_W   = 50;
  localparam int ROOT_W  = 25;
  localparam int RREM_W  = 28;
  localparam int PROD_W  = ROOT_W + 1 + COORD_W;
  localparam int NUM_W   = PROD_W + 2;
  localparam int DEN_W   = ROOT_W + 2;
  localparam int DVD_W   = 52;
  localparam int DVS_W   = DEN_W + 1;
  localparam int QUO_W   = 25;
  localparam int OUT_W   = 24;

  localparam int LAT = 3 + ROOT_W + 3 + QUO_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } tri_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic degenerate;
  } flags_t;

endpackage

// ----- src/ti_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ti_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module ti_sqrt
  import ti_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root
);

  logic [RREM_W-1:0] rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [RREM_W-1:0] r_in;
    logic [ROOT_W-1:0] q_in;
    logic [RAD_W-1:0]  n_in;
    logic [RREM_W-1:0] r_sh;
    logic [RREM_W-1:0] trial;
    logic              take;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign n_in = radicand;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign q_in = root_q[s-1];
      assign n_in = rad_q[s-1];
    end

    assign r_sh  = {r_in[RREM_W-3:0], n_in[RAD_W-1 -: 2]};
    assign trial = {1'b0, q_in, 2'b01};
    assign take  = (r_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[s] <= {q_in[ROOT_W-2:0], take};
      end
    end

    if (s < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s] <= take ? r_sh - trial : r_sh;
          rad_q[s] <= {n_in[RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule

// ----- src/ti_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ti_div
// Pipelined restoring divider, one quotient bit per register stage.
// Quotient must be below 2^QUO_W.
// ----------------------------------------------------------------------------
module ti_div
  import ti_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient
);

  logic [DVS_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [QUO_W-1:0] lo_q  [QUO_W];
  logic [DVS_W-1:0] dvs_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [DVS_W-1:0] r_in;
    logic [QUO_W-1:0] q_in;
    logic [QUO_W-1:0] lo_in;
    logic [DVS_W-1:0] d_in;
    logic [DVS_W:0]   t;
    logic             take;

    if (s == 0) begin : g_first
      assign r_in  = {1'b0, dividend[DVD_W-1:QUO_W]};
      assign q_in  = '0;
      assign lo_in = dividend[QUO_W-1:0];
      assign d_in  = divisor;
    end else begin : g_next
      assign r_in  = rem_q[s-1];
      assign q_in  = quo_q[s-1];
      assign lo_in = lo_q[s-1];
      assign d_in  = dvs_q[s-1];
    end

    assign t    = {r_in, lo_in[QUO_W-1]};
    assign take = (t >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[s] <= {q_in[QUO_W-2:0], take};
      end
    end

    if (s < QUO_W - 1) begin : g_carry
      logic [DVS_W:0] t_sub;
      assign t_sub = t - {1'b0, d_in};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s] <= take ? t_sub[DVS_W-1:0] : t[DVS_W-1:0];
          lo_q[s]  <= {lo_in[QUO_W-2:0], 1'b0};
          dvs_q[s] <= d_in;
        end
      end
    end
  end

  assign quotient = quo_q[QUO_W-1];

endmodule

// ----- src/triangle_incenter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_incenter
// Incenter of a 2-D triangle, side-length weighted, in 1/256 pixel units.
// ----------------------------------------------------------------------------
// Fully pipelined: one triangle transfer per clock while the output is not
// stalled. Most of the pipeline depth lies in the two bit-per-stage units:
// the 25-stage square root for the side lengths and the 25-stage divider
// for the final quotient. The whole pipe advances when the output register
// is empty or being taken, so a stalled result holds everything behind it.
module triangle_incenter
  import ti_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // ax, ay, bx, by_coord, cx, cy (16 bits each, from bit 0)
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // center_x [23:0], center_y [47:24], degenerate [48], zero [55:49]
  output logic [55:0] m_tdata
);

  logic           en;
  logic [LAT-1:0] vld;
  tri_t           in_tri;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];
  assign in_tri   = '{ax: s_tdata[15:0], ay: s_tdata[31:16], bx: s_tdata[47:32],
                      by_coord: s_tdata[63:48], cx: s_tdata[79:64],
                      cy: s_tdata[95:80]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // stage 1: differences
  tri_t                      c1;
  logic signed [DIFF_W-1:0]  dxa, dya, dxb, dyb, dxc, dyc;

  always_ff @(posedge clk) begin
    if (en) begin
      c1  <= in_tri;
      dxa <= DIFF_W'(in_tri.bx) - DIFF_W'(in_tri.cx);
      dya <= DIFF_W'(in_tri.by_coord) - DIFF_W'(in_tri.cy);
      dxb <= DIFF_W'(in_tri.cx) - DIFF_W'(in_tri.ax);
      dyb <= DIFF_W'(in_tri.cy) - DIFF_W'(in_tri.ay);
      dxc <= DIFF_W'(in_tri.ax) - DIFF_W'(in_tri.bx);
      dyc <= DIFF_W'(in_tri.ay) - DIFF_W'(in_tri.by_coord);
    end
  end

  // stage 2: squares
  tri_t                    c2;
  logic signed [SQ_W-1:0]  sxa, sya, sxb, syb, sxc, syc;

  always_ff @(posedge clk) begin
    if (en) begin
      c2  <= c1;
      sxa <= dxa * dxa;
      sya <= dya * dya;
      sxb <= dxb * dxb;
      syb <= dyb * dyb;
      sxc <= dxc * dxc;
      syc <= dyc * dyc;
    end
  end

  // stage 3: squared distances, scaled for 8 fractional root bits
  tri_t             c3;
  logic [RAD_W-1:0] rad_a, rad_b, rad_c;
  logic [SQ_W-1:0]  d2a, d2b, d2c;

  assign d2a = sxa + sya;
  assign d2b = sxb + syb;
  assign d2c = sxc + syc;

  always_ff @(posedge clk) begin
    if (en) begin
      c3    <= c2;
      rad_a <= {1'b0, d2a[D2_W-1:0], (2 * FRAC_W)'(0)};
      rad_b <= {1'b0, d2b[D2_W-1:0], (2 * FRAC_W)'(0)};
      rad_c <= {1'b0, d2c[D2_W-1:0], (2 * FRAC_W)'(0)};
    end
  end

  logic [ROOT_W-1:0] la, lb, lc;

  ti_sqrt u_sqrt_a (.clk(clk), .en(en), .radicand(rad_a), .root(la));
  ti_sqrt u_sqrt_b (.clk(clk), .en(en), .radicand(rad_b), .root(lb));
  ti_sqrt u_sqrt_c (.clk(clk), .en(en), .radicand(rad_c), .root(lc));

  tri_t cd [ROOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      cd[0] <= c3;
      for (int i = 1; i < ROOT_W; i++) begin
        cd[i] <= cd[i-1];
      end
    end
  end

  // stage 4: weighted products and denominator
  tri_t                     ct;
  logic signed [PROD_W-1:0] pxa, pya, pxb, pyb, pxc, pyc;
  logic [DEN_W-1:0]         den4;

  assign ct = cd[ROOT_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      pxa  <= $signed({1'b0, la}) * ct.ax;
      pya  <= $signed({1'b0, la}) * ct.ay;
      pxb  <= $signed({1'b0, lb}) * ct.bx;
      pyb  <= $signed({1'b0, lb}) * ct.by_coord;
      pxc  <= $signed({1'b0, lc}) * ct.cx;
      pyc  <= $signed({1'b0, lc}) * ct.cy;
      den4 <= DEN_W'(la) + DEN_W'(lb) + DEN_W'(lc);
    end
  end

  // stage 5: numerators
  logic signed [NUM_W-1:0] nx, ny;
  logic [DEN_W-1:0]        den5;

  always_ff @(posedge clk) begin
    if (en) begin
      nx   <= NUM_W'(pxa) + NUM_W'(pxb) + NUM_W'(pxc);
      ny   <= NUM_W'(pya) + NUM_W'(pyb) + NUM_W'(pyc);
      den5 <= den4;
    end
  end

  // stage 6: magnitudes, rounding offset folded into the dividend
  logic [NUM_W-1:0]       mag_x, mag_y;
  logic [DVD_W:0]         sum_x, sum_y;
  logic [DVD_W-1:0]       dvd_x, dvd_y;
  logic [DVS_W-1:0]       dvs;
  flags_t                 fl6;

  assign mag_x = nx[NUM_W-1] ? NUM_W'(-nx) : NUM_W'(nx);
  assign mag_y = ny[NUM_W-1] ? NUM_W'(-ny) : NUM_W'(ny);
  assign sum_x = {mag_x, (FRAC_W + 1)'(0)} + (DVD_W + 1)'(den5);
  assign sum_y = {mag_y, (FRAC_W + 1)'(0)} + (DVD_W + 1)'(den5);

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_x <= sum_x[DVD_W-1:0];
      dvd_y <= sum_y[DVD_W-1:0];
      dvs   <= {den5, 1'b0};
      fl6   <= '{neg_x: nx[NUM_W-1], neg_y: ny[NUM_W-1], degenerate: (den5 == '0)};
    end
  end

  logic [QUO_W-1:0] qx, qy;

  ti_div u_div_x (.clk(clk), .en(en), .dividend(dvd_x), .divisor(dvs), .quotient(qx));
  ti_div u_div_y (.clk(clk), .en(en), .dividend(dvd_y), .divisor(dvs), .quotient(qy));

  flags_t fd [QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      fd[0] <= fl6;
      for (int i = 1; i < QUO_W; i++) begin
        fd[i] <= fd[i-1];
      end
    end
  end

  // stage 7: sign and output register
  flags_t           fo;
  logic [QUO_W-1:0] sx, sy;

  assign fo = fd[QUO_W-1];
  assign sx = fo.neg_x ? -qx : qx;
  assign sy = fo.neg_y ? -qy : qy;

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {7'b0, fo.degenerate,
                  fo.degenerate ? OUT_W'(0) : sy[OUT_W-1:0],
                  fo.degenerate ? OUT_W'(0) : sx[OUT_W-1:0]};
    end
  end

endmodule
